### hdl/alarm_timer_queue_defines.svh
// assertion macros for the alarm timer queue
`ifndef ALARM_TIMER_QUEUE_DEFINES_SVH
`define ALARM_TIMER_QUEUE_DEFINES_SVH

// same-cycle implication, checked outside reset
`define ATQ_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, checked outside reset
`define ATQ_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### hdl/atq_pkg.sv
// types, constants and helpers shared by the alarm timer queue
`default_nettype none
package atq_pkg;

   localparam int NUM_ALARMS  = 16;
   localparam int ID_BITS     = 16;
   localparam int MAX_RESULTS = 16;
   localparam int COUNT_BITS  = $clog2(MAX_RESULTS);

   typedef enum logic [1:0] {
      FN_SET    = 2'd0,
      FN_CANCEL = 2'd1,
      FN_TICK   = 2'd2
   } func_type;

   typedef enum logic [2:0] {
      ST_SET_NEW      = 3'd0,
      ST_SET_REPLACED = 3'd1,
      ST_SET_FULL     = 3'd2,
      ST_CANCELLED    = 3'd3,
      ST_NOT_FOUND    = 3'd4,
      ST_FIRED        = 3'd5
   } status_type;

   typedef enum logic [1:0] {
      OP_HOLD   = 2'd0,
      OP_REMOVE = 2'd1,
      OP_INSERT = 2'd2
   } cell_op_type;

   typedef struct packed {
      logic               valid;
      logic [ID_BITS-1:0] id;
      logic [31:0]        due;
      logic [31:0]        tag;
   } entry_type;

   typedef struct packed {
      cell_op_type        op;
      logic               match_en;
      logic [ID_BITS-1:0] key_id;
      entry_type          new_ent;
   } cell_ctrl_type;

   localparam entry_type EMPTY_ENTRY = '0;

   // wrap-safe: a is earlier than b
   function automatic logic earlier(input logic [31:0] a, input logic [31:0] b);
      logic [31:0] diff;
      diff = a - b;
      return diff[31];
   endfunction

   function automatic logic [ID_BITS-1:0] to_id(input logic [15:0] a);
      logic [ID_BITS+15:0] w;
      w = {{ID_BITS{1'b0}}, a};
      return w[ID_BITS-1:0];
   endfunction

   function automatic logic [15:0] from_id(input logic [ID_BITS-1:0] a);
      logic [ID_BITS+15:0] w;
      w = {16'b0, a};
      return w[15:0];
   endfunction

endpackage
`default_nettype wire

### hdl/atq_cell.sv
// one slot of the sorted alarm chain
`default_nettype none
module atq_cell import atq_pkg::*; (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire cell_ctrl_type ctrl,
   input  wire entry_type     left_ent,
   input  wire entry_type     right_ent,
   input  wire logic          rm_in,
   input  wire logic          ins_in,
   output entry_type          entry,
   output logic               rm_out,
   output logic               ins_out
);

   entry_type entry_ff, entry_in;
   logic      match;

   assign match   = ctrl.match_en & entry_ff.valid & (entry_ff.id == ctrl.key_id);
   assign rm_out  = rm_in | match;
   // still ahead of the new alarm
   assign ins_out = ins_in & entry_ff.valid & earlier(entry_ff.due, ctrl.new_ent.due);
   assign entry   = entry_ff;

   always_comb begin
      entry_in = entry_ff;
      unique case (ctrl.op)
         OP_REMOVE: begin
            if (rm_out) entry_in = right_ent;
         end
         OP_INSERT: begin
            if (!ins_out) entry_in = ins_in ? ctrl.new_ent : left_ent;
         end
         OP_HOLD: ;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_ff.valid <= 1'b0;
      end else begin
         entry_ff <= entry_in;
      end
   end

endmodule
`default_nettype wire

### hdl/alarm_timer_queue.sv
// top level: sorted one-shot alarm queue built as a chain of slot cells
// order: a set word is registered out of S_REMOVE then S_INSERT, a cancel word out of S_REMOVE,
//   the first fired word out of S_POP and each later fired word in the cycle after the one before
// the sequencer drives the shared cell chain one operation a cycle: remove then insert for a set,
//   remove for a cancel, one pop per fired alarm (an empty pop when none is due) for a tick
// reset: synchronous, clears the seconds counter and slot valid bits; receiver cannot stall
`default_nettype none
`include "alarm_timer_queue_defines.svh"
module alarm_timer_queue import atq_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic [1:0]  req_func,
   input  wire logic [15:0] req_alarm_key,
   input  wire logic [15:0] req_delay_seconds,
   input  wire logic [31:0] req_user_tag,
   output logic             rsp_strobe,
   output logic [2:0]       rsp_status,
   output logic [15:0]      rsp_fired_id,
   output logic [31:0]      rsp_fired_tag,
   output logic             rsp_last
);

   // one-hot sequencer
   typedef enum logic [3:0] {
      S_IDLE   = 4'b0001,
      S_REMOVE = 4'b0010,
      S_INSERT = 4'b0100,
      S_POP    = 4'b1000
   } state_type;

   state_type            state_ff, state_in;
   logic [31:0]          now_ff, now_in;
   func_type             func_ff, func_in;
   logic [ID_BITS-1:0]   id_ff, id_in;
   logic [31:0]          due_ff, due_in;
   logic [31:0]          tag_ff, tag_in;
   status_type           set_status_ff, set_status_in;
   logic [COUNT_BITS-1:0] count_ff, count_in;

   logic                 rsp_strobe_ff, rsp_strobe_in;
   status_type           rsp_status_ff, rsp_status_in;
   logic [15:0]          rsp_id_ff, rsp_id_in;
   logic [31:0]          rsp_tag_ff, rsp_tag_in;
   logic                 rsp_last_ff, rsp_last_in;

   // chain wiring
   cell_ctrl_type        ctrl;
   logic                 pop_head;
   entry_type            ent [NUM_ALARMS];
   logic                 rm_chain  [NUM_ALARMS+1];
   logic                 ins_chain [NUM_ALARMS+1];

   logic any_match, list_full, head_due, next_due, fire_last;

   assign rm_chain[0]  = pop_head;
   assign ins_chain[0] = 1'b1;

   genvar gi;
   generate
      for (gi = 0; gi < NUM_ALARMS; gi++) begin : g_cell
         entry_type left_ent, right_ent;
         if (gi == 0) begin : g_first
            assign left_ent = EMPTY_ENTRY;
         end else begin : g_mid_l
            assign left_ent = ent[gi-1];
         end
         if (gi == NUM_ALARMS-1) begin : g_last
            assign right_ent = EMPTY_ENTRY;
         end else begin : g_mid_r
            assign right_ent = ent[gi+1];
         end
         atq_cell u_cell (
            .clock     (clock),
            .reset     (reset),
            .ctrl      (ctrl),
            .left_ent  (left_ent),
            .right_ent (right_ent),
            .rm_in     (rm_chain[gi]),
            .ins_in    (ins_chain[gi]),
            .entry     (ent[gi]),
            .rm_out    (rm_chain[gi+1]),
            .ins_out   (ins_chain[gi+1])
         );
      end
   endgenerate

   // id match anywhere in the list, seen at the tail of the or chain
   assign any_match = rm_chain[NUM_ALARMS];
   assign list_full = ent[NUM_ALARMS-1].valid;
   // a due follower keeps the burst going, up to MAX_RESULTS words, else this firing is the last word
   assign head_due  = ent[0].valid & !earlier(now_ff, ent[0].due);
   assign next_due  = ent[1].valid & !earlier(now_ff, ent[1].due);
   assign fire_last = !next_due || (count_ff == COUNT_BITS'(MAX_RESULTS-1));

   assign busy = (state_ff != S_IDLE);

   always_comb begin
      state_in      = state_ff;
      now_in        = now_ff;
      func_in       = func_ff;
      id_in         = id_ff;
      due_in        = due_ff;
      tag_in        = tag_ff;
      set_status_in = set_status_ff;
      count_in      = count_ff;
      rsp_strobe_in = 1'b0;
      rsp_status_in = rsp_status_ff;
      rsp_id_in     = rsp_id_ff;
      rsp_tag_in    = rsp_tag_ff;
      rsp_last_in   = rsp_last_ff;
      pop_head      = 1'b0;

      ctrl.op            = OP_HOLD;
      ctrl.match_en      = 1'b0;
      ctrl.key_id        = id_ff;
      ctrl.new_ent.valid = 1'b1;
      ctrl.new_ent.id    = id_ff;
      ctrl.new_ent.due   = due_ff;
      ctrl.new_ent.tag   = tag_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               func_in  = func_type'(req_func);
               id_in    = to_id(req_alarm_key);
               due_in   = now_ff + {16'b0, req_delay_seconds};
               tag_in   = req_user_tag;
               count_in = '0;
               unique case (req_func)
                  FN_SET, FN_CANCEL: begin
                     state_in = S_REMOVE;
                  end
                  FN_TICK: begin
                     now_in   = now_ff + 32'd1;
                     state_in = S_POP;
                  end
                  default: ; // unused code: dropped without a word
               endcase
            end
         end
         S_REMOVE: begin
            // drop any slot with this id, closing the gap
            ctrl.op       = OP_REMOVE;
            ctrl.match_en = 1'b1;
            rsp_id_in     = from_id(id_ff);
            rsp_tag_in    = '0;
            rsp_last_in   = 1'b1;
            if (func_ff == FN_CANCEL) begin
               rsp_strobe_in = 1'b1;
               rsp_status_in = any_match ? ST_CANCELLED : ST_NOT_FOUND;
               state_in      = S_IDLE;
            end else if (!any_match && list_full) begin
               rsp_strobe_in = 1'b1;
               rsp_status_in = ST_SET_FULL;
               state_in      = S_IDLE;
            end else begin
               set_status_in = any_match ? ST_SET_REPLACED : ST_SET_NEW;
               state_in      = S_INSERT;
            end
         end
         S_INSERT: begin
            // new alarm goes ahead of the first slot not earlier than it
            ctrl.op       = OP_INSERT;
            rsp_strobe_in = 1'b1;
            rsp_status_in = set_status_ff;
            state_in      = S_IDLE;
         end
         S_POP: begin
            ctrl.op = OP_REMOVE;
            if (head_due) begin
               pop_head      = 1'b1;
               rsp_strobe_in = 1'b1;
               rsp_status_in = ST_FIRED;
               rsp_id_in     = from_id(ent[0].id);
               rsp_tag_in    = ent[0].tag;
               rsp_last_in   = fire_last;
               count_in      = count_ff + COUNT_BITS'(1);
               if (fire_last) state_in = S_IDLE;
            end else begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         now_ff        <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         now_ff        <= now_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   // request and result word payload, no reset needed
   always_ff @(posedge clock) begin
      func_ff       <= func_in;
      id_ff         <= id_in;
      due_ff        <= due_in;
      tag_ff        <= tag_in;
      set_status_ff <= set_status_in;
      count_ff      <= count_in;
      rsp_status_ff <= rsp_status_in;
      rsp_id_ff     <= rsp_id_in;
      rsp_tag_ff    <= rsp_tag_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_strobe    = rsp_strobe_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_fired_id  = rsp_id_ff;
   assign rsp_fired_tag = rsp_tag_ff;
   assign rsp_last      = rsp_last_ff;

   // a burst of fired words runs without gaps until its last word
   `ATQ_ASSERT_NEXT(a_fire_burst, rsp_strobe && !rsp_last, rsp_strobe && rsp_status == ST_FIRED, "fired burst broken")
   // set and cancel give a single word
   `ATQ_ASSERT_SAME(a_single_word, rsp_strobe && rsp_status != ST_FIRED, rsp_last, "set or cancel word not last")
   // only fired words carry a tag
   `ATQ_ASSERT_SAME(a_tag_zero, rsp_strobe && rsp_status != ST_FIRED, rsp_fired_tag == 32'd0, "tag on non-fired word")

endmodule
`default_nettype wire
